FILE: hw/rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared widths and command codes for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  localparam int FIELD_BITS = 8;
  localparam int COLOR_BITS = 16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Input stage: takes command beats, registers them and works out the line
// setup (steepness, axis swap, endpoint order, spans, initial error) for loads.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_front #(
  parameter int COORD_BITS = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           command,
  input  wire  [lr_pkg::FIELD_BITS-1:0] x_start,
  input  wire  [lr_pkg::FIELD_BITS-1:0] y_start,
  input  wire  [lr_pkg::FIELD_BITS-1:0] x_end,
  input  wire  [lr_pkg::FIELD_BITS-1:0] y_end,
  input  wire  [lr_pkg::COLOR_BITS-1:0] line_color,
  output logic                          push,
  input  wire                           queue_full,
  output logic                          ent_load,
  output logic                          ent_steep,
  output logic [COORD_BITS-1:0]         ent_major,
  output logic [COORD_BITS-1:0]         ent_stop,
  output logic [COORD_BITS-1:0]         ent_minor,
  output logic                          ent_down,
  output logic [COORD_BITS-1:0]         ent_span_major,
  output logic [COORD_BITS-1:0]         ent_span_minor,
  output logic [COORD_BITS:0]           ent_error,
  output logic [lr_pkg::COLOR_BITS-1:0] ent_color
);
  import lr_pkg::*;

  logic                  stg_valid;
  cmd_t                  stg_cmd;
  logic [COORD_BITS-1:0] stg_xs;
  logic [COORD_BITS-1:0] stg_ys;
  logic [COORD_BITS-1:0] stg_xe;
  logic [COORD_BITS-1:0] stg_ye;
  logic [COLOR_BITS-1:0] stg_color;
  logic                  in_fire;

  assign in_stall = stg_valid && queue_full;
  assign in_fire  = in_valid && !in_stall;
  assign push     = stg_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_fire) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_cmd   <= cmd_t'(command);
      stg_xs    <= COORD_BITS'(x_start);
      stg_ys    <= COORD_BITS'(y_start);
      stg_xe    <= COORD_BITS'(x_end);
      stg_ye    <= COORD_BITS'(y_end);
      stg_color <= line_color;
    end
  end

  always_comb begin
    logic [COORD_BITS-1:0] dx_abs;
    logic [COORD_BITS-1:0] dy_abs;
    logic                  steep;
    logic [COORD_BITS-1:0] p0;
    logic [COORD_BITS-1:0] q0;
    logic [COORD_BITS-1:0] p1;
    logic [COORD_BITS-1:0] q1;
    logic                  swap;
    logic [COORD_BITS-1:0] mn_end;
    logic [COORD_BITS-1:0] span;

    dx_abs = (stg_xs > stg_xe) ? (stg_xs - stg_xe) : (stg_xe - stg_xs);
    dy_abs = (stg_ys > stg_ye) ? (stg_ys - stg_ye) : (stg_ye - stg_ys);
    steep  = dy_abs > dx_abs;
    p0 = steep ? stg_ys : stg_xs;
    q0 = steep ? stg_xs : stg_ys;
    p1 = steep ? stg_ye : stg_xe;
    q1 = steep ? stg_xe : stg_ye;
    swap = p0 > p1;

    ent_load       = (stg_cmd == CMD_LOAD);
    ent_steep      = steep;
    ent_major      = swap ? p1 : p0;
    ent_stop       = swap ? p0 : p1;
    ent_minor      = swap ? q1 : q0;
    mn_end         = swap ? q0 : q1;
    ent_down       = !(ent_minor < mn_end);
    span           = ent_stop - ent_major;
    ent_span_major = span;
    ent_span_minor = steep ? dx_abs : dy_abs;
    ent_error      = {2'b00, span[COORD_BITS-1:1]};
    ent_color      = stg_color;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lr_queue.sv
// ----------------------------------------------------------------------------
// lr_queue
// Two-entry register queue between the setup stage and the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_queue #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire  [WIDTH-1:0] push_data,
  output logic             full,
  input  wire              pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = count[1];
  assign not_empty = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Stepper: holds the active line, runs one Bresenham step per step beat and
// drives the registered pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_back #(
  parameter int COORD_BITS = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           q_valid,
  output logic                          q_pop,
  input  wire                           ent_load,
  input  wire                           ent_steep,
  input  wire  [COORD_BITS-1:0]         ent_major,
  input  wire  [COORD_BITS-1:0]         ent_stop,
  input  wire  [COORD_BITS-1:0]         ent_minor,
  input  wire                           ent_down,
  input  wire  [COORD_BITS-1:0]         ent_span_major,
  input  wire  [COORD_BITS-1:0]         ent_span_minor,
  input  wire  [COORD_BITS:0]           ent_error,
  input  wire  [lr_pkg::COLOR_BITS-1:0] ent_color,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [lr_pkg::FIELD_BITS-1:0] pixel_x,
  output logic [lr_pkg::FIELD_BITS-1:0] pixel_y,
  output logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                          last_pixel
);
  import lr_pkg::*;

  logic                  busy;
  logic                  steep_flag;
  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] major_stop;
  logic [COORD_BITS-1:0] minor_pos;
  logic                  minor_down;
  logic [COORD_BITS-1:0] span_major;
  logic [COORD_BITS-1:0] span_minor;
  logic signed [COORD_BITS:0] error_term;
  logic [COLOR_BITS-1:0] held_color;

  logic                  advance;
  logic                  do_step;
  logic                  last;
  logic signed [COORD_BITS:0] err_sub;

  assign advance = !out_valid || !out_stall;
  assign q_pop   = q_valid && advance;
  assign do_step = q_pop && !ent_load && busy;
  assign last    = (major_pos == major_stop);
  assign err_sub = error_term - $signed({1'b0, span_minor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      steep_flag <= 1'b0;
      major_pos  <= '0;
      major_stop <= '0;
      minor_pos  <= '0;
      minor_down <= 1'b0;
      span_major <= '0;
      span_minor <= '0;
      error_term <= '0;
      held_color <= '0;
    end else if (q_pop && ent_load) begin
      busy       <= 1'b1;
      steep_flag <= ent_steep;
      major_pos  <= ent_major;
      major_stop <= ent_stop;
      minor_pos  <= ent_minor;
      minor_down <= ent_down;
      span_major <= ent_span_major;
      span_minor <= ent_span_minor;
      error_term <= $signed(ent_error);
      held_color <= ent_color;
    end else if (do_step) begin
      if (err_sub < 0) begin
        minor_pos  <= minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
        error_term <= err_sub + $signed({1'b0, span_major});
      end else begin
        error_term <= err_sub;
      end
      if (last) begin
        busy <= 1'b0;
      end else begin
        major_pos <= major_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= do_step;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      pixel_x     <= FIELD_BITS'(steep_flag ? minor_pos : major_pos);
      pixel_y     <= FIELD_BITS'(steep_flag ? major_pos : minor_pos);
      pixel_color <= held_color;
      last_pixel  <= last;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line generator: a load beat sets up a line, each step beat
// returns the next pixel of it with its color and a last flag.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   command, x_start, y_start,
//                                             x_end, y_end, line_color
//   out      output     out_valid / out_stall pixel_x, pixel_y, pixel_color,
//                                             last_pixel
//
// One beat is taken per cycle while in_stall is low; a step beat's pixel passes
// through the input register, the two-entry queue and the pixel register.
// The stepper does one subtract, compare and add on the error per step beat.
// Synchronous reset clears the active line and empties the queue.
// A stalled output holds the stepper; input stalls only once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer #(
  parameter int COORD_BITS = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           command,
  input  wire  [lr_pkg::FIELD_BITS-1:0] x_start,
  input  wire  [lr_pkg::FIELD_BITS-1:0] y_start,
  input  wire  [lr_pkg::FIELD_BITS-1:0] x_end,
  input  wire  [lr_pkg::FIELD_BITS-1:0] y_end,
  input  wire  [lr_pkg::COLOR_BITS-1:0] line_color,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [lr_pkg::FIELD_BITS-1:0] pixel_x,
  output logic [lr_pkg::FIELD_BITS-1:0] pixel_y,
  output logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                          last_pixel
);
  import lr_pkg::*;

  localparam int ENTRY_BITS = 6 * COORD_BITS + 4 + COLOR_BITS;

  logic                  push;
  logic                  queue_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [ENTRY_BITS-1:0] q_in;
  logic [ENTRY_BITS-1:0] q_out;

  logic                  f_load;
  logic                  f_steep;
  logic [COORD_BITS-1:0] f_major;
  logic [COORD_BITS-1:0] f_stop;
  logic [COORD_BITS-1:0] f_minor;
  logic                  f_down;
  logic [COORD_BITS-1:0] f_span_major;
  logic [COORD_BITS-1:0] f_span_minor;
  logic [COORD_BITS:0]   f_error;
  logic [COLOR_BITS-1:0] f_color;

  logic                  b_load;
  logic                  b_steep;
  logic [COORD_BITS-1:0] b_major;
  logic [COORD_BITS-1:0] b_stop;
  logic [COORD_BITS-1:0] b_minor;
  logic                  b_down;
  logic [COORD_BITS-1:0] b_span_major;
  logic [COORD_BITS-1:0] b_span_minor;
  logic [COORD_BITS:0]   b_error;
  logic [COLOR_BITS-1:0] b_color;

  lr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .x_start       (x_start),
    .y_start       (y_start),
    .x_end         (x_end),
    .y_end         (y_end),
    .line_color    (line_color),
    .push          (push),
    .queue_full    (queue_full),
    .ent_load      (f_load),
    .ent_steep     (f_steep),
    .ent_major     (f_major),
    .ent_stop      (f_stop),
    .ent_minor     (f_minor),
    .ent_down      (f_down),
    .ent_span_major(f_span_major),
    .ent_span_minor(f_span_minor),
    .ent_error     (f_error),
    .ent_color     (f_color)
  );

  assign q_in = {f_load, f_steep, f_major, f_stop, f_minor, f_down,
                 f_span_major, f_span_minor, f_error, f_color};

  lr_queue #(
    .WIDTH(ENTRY_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(q_in),
    .full     (queue_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .not_empty(q_valid)
  );

  assign {b_load, b_steep, b_major, b_stop, b_minor, b_down,
          b_span_major, b_span_minor, b_error, b_color} = q_out;

  lr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .ent_load      (b_load),
    .ent_steep     (b_steep),
    .ent_major     (b_major),
    .ent_stop      (b_stop),
    .ent_minor     (b_minor),
    .ent_down      (b_down),
    .ent_span_major(b_span_major),
    .ent_span_minor(b_span_minor),
    .ent_error     (b_error),
    .ent_color     (b_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lr_checker.sv
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           command,
  input wire  [lr_pkg::FIELD_BITS-1:0] x_start,
  input wire  [lr_pkg::FIELD_BITS-1:0] y_start,
  input wire  [lr_pkg::FIELD_BITS-1:0] x_end,
  input wire  [lr_pkg::FIELD_BITS-1:0] y_end,
  input wire  [lr_pkg::COLOR_BITS-1:0] line_color,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire  [lr_pkg::FIELD_BITS-1:0] pixel_x,
  input wire  [lr_pkg::FIELD_BITS-1:0] pixel_y,
  input wire  [lr_pkg::COLOR_BITS-1:0] pixel_color,
  input wire                           last_pixel
);

  a_in_stable: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(command) && $stable(x_start) &&
                             $stable(y_start) && $stable(x_end) && $stable(y_end) &&
                             $stable(line_color))
    else $error("Input beat changed while stalled.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y) &&
                              $stable(pixel_color) && $stable(last_pixel))
    else $error("Output payload changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Block not idle after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("Input stalled without a stalled output.");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

`default_nettype wire
